/* hdl/tfas_pkg.sv */
// Shared types and constants for the temporal frame averaging block.
package tfas_pkg;

   localparam int CNT_W   = 5;   // frame counts and register fields of five bits
   localparam int DIM_W   = 9;   // frame size register fields
   localparam int CSR_W   = 9;   // configuration write data
   localparam int IDX_W   = 2;   // configuration register index
   localparam int SUM_W   = 13;  // sum of up to 31 channel values
   localparam int DCNT_W  = 4;   // divider step counter

   localparam logic [IDX_W-1:0] REG_FRAMES_TO_KEEP = 2'd0;
   localparam logic [IDX_W-1:0] REG_FRAME_STRIDE   = 2'd1;
   localparam logic [IDX_W-1:0] REG_FRAME_WIDTH    = 2'd2;
   localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT   = 2'd3;

   localparam logic [CNT_W-1:0] KEEP_RESET   = 5'd16;
   localparam logic [CNT_W-1:0] STRIDE_RESET = 5'd4;
   localparam logic [DIM_W-1:0] DIM_RESET    = 9'd256;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE,
      ST_READ,
      ST_DRAIN,
      ST_DIVIDE,
      ST_DONE
   } state_type;

endpackage

/* hdl/temporal_frame_average_stride.sv */
// Temporal frame averaging over a ring of frame stores held in one memory.
//
// Pixels arrive on the req_ channel in raster order and one averaged pixel
// leaves on the rsp_ channel for every input transaction. Each pixel is
// written into the newest frame slot, then the stored words at the same
// position in the newest frame and every stride-th older kept frame are read
// back one per cycle from the single memory read port and summed per channel.
// A restoring divider then divides the four sums by the frame count together.
// Each pixel passes through the write, read, drain, divide and done states
// on its way to the result register; a new pixel is accepted once the
// previous result has been moved to the output register.
// The result register holds its transaction while rsp_ready is low; a held
// result stalls the next pixel only at its final step.
// The csr_ channel writes frames_to_keep, frame_stride, frame_width and
// frame_height; a size write empties the history and restarts the frame.
// A register write is only taken while no pixel is being processed, and it
// takes precedence over a pixel offered in the same cycle.
// Reset restores the register defaults and an empty history; the memory
// itself is not cleared, and stored words are only read once written.
module temporal_frame_average_stride #(
   parameter int MAX_FRAMES = 16,
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [31:0]                   req_pixel_argb,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [7:0]                    rsp_avg_red,
   output logic [7:0]                    rsp_avg_green,
   output logic [7:0]                    rsp_avg_blue,
   output logic [7:0]                    rsp_avg_alpha,
   output logic [tfas_pkg::CNT_W-1:0]    rsp_frames_used,
   output logic                          rsp_end_of_frame,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [tfas_pkg::IDX_W-1:0]    csr_index,
   input  logic [tfas_pkg::CSR_W-1:0]    csr_data
);

   localparam int FRAME_WORDS = MAX_WIDTH * MAX_HEIGHT;
   localparam int MEM_DEPTH   = MAX_FRAMES * FRAME_WORDS;
   localparam int ADDR_W      = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
   localparam int SLOT_W      = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int TOT_W       = $clog2(FRAME_WORDS + 1);
   localparam int CW          = tfas_pkg::CNT_W;
   localparam int SW          = tfas_pkg::SUM_W;

   logic [31:0] mem [MEM_DEPTH];

   tfas_pkg::state_type state_ff, state_in;

   logic [CW-1:0]  keep_cfg_ff, stride_cfg_ff;
   logic [tfas_pkg::DIM_W-1:0] width_cfg_ff, height_cfg_ff;

   logic [SLOT_W-1:0] newest_ff;
   logic [CW-1:0]     kept_ff;
   logic [TOT_W-1:0]  pos_ff;

   logic [TOT_W-1:0]  item_pos_ff;
   logic              item_last_ff;
   logic [31:0]       item_pix_ff;

   logic [CW:0]       off_ff;
   logic [CW-1:0]     n_ff;
   logic              rd_pend_ff;
   logic [31:0]       rd_data_ff;
   logic [SW-1:0]     sum_ff [4];
   logic [CW-1:0]     rem_ff [4];
   logic [tfas_pkg::DCNT_W-1:0] dcnt_ff;

   logic              rsp_valid_ff;
   logic [7:0]        rsp_ch_ff [4];
   logic [CW-1:0]     rsp_n_ff;
   logic              rsp_last_ff;

   // Derived frame geometry and limits.
   int unsigned w_eff, h_eff;
   logic [TOT_W-1:0] total;
   logic [CW-1:0]    keep_eff, stride_eff;
   always_comb begin
      w_eff = (width_cfg_ff == '0) ? 1 :
              ((32'(width_cfg_ff) > MAX_WIDTH) ? MAX_WIDTH : 32'(width_cfg_ff));
      h_eff = (height_cfg_ff == '0) ? 1 :
              ((32'(height_cfg_ff) > MAX_HEIGHT) ? MAX_HEIGHT : 32'(height_cfg_ff));
      total = TOT_W'(w_eff * h_eff);
      keep_eff = (32'(keep_cfg_ff) > MAX_FRAMES) ? CW'(MAX_FRAMES) : keep_cfg_ff;
      stride_eff = (stride_cfg_ff == '0) ? CW'(1) : stride_cfg_ff;
   end

   logic req_fire, rsp_fire, csr_fire, issue, out_load;
   assign req_ready = (state_ff == tfas_pkg::ST_IDLE) && !csr_valid;
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid_ff && rsp_ready;
   assign csr_ready = (state_ff == tfas_pkg::ST_IDLE);
   assign csr_fire  = csr_valid && csr_ready;
   assign issue     = (state_ff == tfas_pkg::ST_READ) && ({1'b0, kept_ff} > off_ff);
   assign out_load  = (state_ff == tfas_pkg::ST_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tfas_pkg::ST_IDLE:   if (req_fire) state_in = tfas_pkg::ST_WRITE;
         tfas_pkg::ST_WRITE:  state_in = tfas_pkg::ST_READ;
         tfas_pkg::ST_READ:   if (!issue) state_in = tfas_pkg::ST_DRAIN;
         tfas_pkg::ST_DRAIN:  state_in = tfas_pkg::ST_DIVIDE;
         tfas_pkg::ST_DIVIDE: begin
            if (dcnt_ff == tfas_pkg::DCNT_W'(SW - 1)) state_in = tfas_pkg::ST_DONE;
         end
         tfas_pkg::ST_DONE:   if (out_load) state_in = tfas_pkg::ST_IDLE;
         default:             state_in = tfas_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tfas_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Configuration registers and ring position.
   logic [TOT_W-1:0]  pos_now;
   logic [SLOT_W-1:0] newest_next;
   logic [CW:0]       kept_inc;
   always_comb begin
      pos_now = (pos_ff >= total) ? '0 : pos_ff;
      newest_next = (newest_ff == SLOT_W'(MAX_FRAMES - 1)) ? '0 : newest_ff + 1'b1;
      kept_inc = {1'b0, kept_ff} + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         keep_cfg_ff   <= tfas_pkg::KEEP_RESET;
         stride_cfg_ff <= tfas_pkg::STRIDE_RESET;
         width_cfg_ff  <= tfas_pkg::DIM_RESET;
         height_cfg_ff <= tfas_pkg::DIM_RESET;
         newest_ff     <= '0;
         kept_ff       <= '0;
         pos_ff        <= '0;
      end else if (csr_fire) begin
         case (csr_index)
            tfas_pkg::REG_FRAMES_TO_KEEP: keep_cfg_ff <= csr_data[CW-1:0];
            tfas_pkg::REG_FRAME_STRIDE:   stride_cfg_ff <= csr_data[CW-1:0];
            tfas_pkg::REG_FRAME_WIDTH: begin
               width_cfg_ff <= csr_data;
               newest_ff <= '0;
               kept_ff   <= '0;
               pos_ff    <= '0;
            end
            tfas_pkg::REG_FRAME_HEIGHT: begin
               height_cfg_ff <= csr_data;
               newest_ff <= '0;
               kept_ff   <= '0;
               pos_ff    <= '0;
            end
            default: ;
         endcase
      end else if (req_fire) begin
         if (pos_now == '0) begin
            newest_ff <= newest_next;
            kept_ff   <= (kept_inc < {1'b0, keep_eff}) ? kept_inc[CW-1:0] : keep_eff;
         end
         pos_ff <= (pos_now + 1'b1 == total) ? '0 : pos_now + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_pos_ff  <= pos_now;
         item_last_ff <= (pos_now + 1'b1 == total);
         item_pix_ff  <= req_pixel_argb;
      end
   end

   // Memory addressing: write the newest slot, then read back the newest and older slots.
   logic [SLOT_W-1:0] rd_slot;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   always_comb begin
      rd_slot = (32'(newest_ff) >= 32'(off_ff)) ? SLOT_W'(32'(newest_ff) - 32'(off_ff)) :
                SLOT_W'(32'(newest_ff) + MAX_FRAMES - 32'(off_ff));
      wr_addr = ADDR_W'(ADDR_W'(newest_ff) * ADDR_W'(FRAME_WORDS)) + ADDR_W'(item_pos_ff);
      rd_addr = ADDR_W'(ADDR_W'(rd_slot) * ADDR_W'(FRAME_WORDS)) + ADDR_W'(item_pos_ff);
   end

   always_ff @(posedge clock) begin
      if (state_ff == tfas_pkg::ST_WRITE) begin
         mem[wr_addr] <= item_pix_ff;
      end
      if (issue) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff <= 1'b0;
      end else begin
         rd_pend_ff <= issue;
      end
   end

   // Read loop counters and per-channel accumulate, then restoring division.
   always_ff @(posedge clock) begin
      if (state_ff == tfas_pkg::ST_WRITE) begin
         off_ff  <= '0;
         n_ff    <= '0;
         dcnt_ff <= '0;
         for (int c = 0; c < 4; c++) begin
            sum_ff[c] <= '0;
            rem_ff[c] <= '0;
         end
      end else if (state_ff == tfas_pkg::ST_DIVIDE) begin
         dcnt_ff <= dcnt_ff + 1'b1;
         for (int c = 0; c < 4; c++) begin
            if ({rem_ff[c], sum_ff[c][SW-1]} >= {1'b0, n_ff}) begin
               rem_ff[c] <= CW'({rem_ff[c], sum_ff[c][SW-1]} - {1'b0, n_ff});
               sum_ff[c] <= {sum_ff[c][SW-2:0], 1'b1};
            end else begin
               rem_ff[c] <= CW'({rem_ff[c], sum_ff[c][SW-1]});
               sum_ff[c] <= {sum_ff[c][SW-2:0], 1'b0};
            end
         end
      end else begin
         if (issue) begin
            off_ff <= off_ff + {1'b0, stride_eff};
            n_ff   <= n_ff + 1'b1;
         end
         if (rd_pend_ff) begin
            // Channel order in the sums: red, green, blue, alpha.
            sum_ff[0] <= sum_ff[0] + SW'(rd_data_ff[23:16]);
            sum_ff[1] <= sum_ff[1] + SW'(rd_data_ff[15:8]);
            sum_ff[2] <= sum_ff[2] + SW'(rd_data_ff[7:0]);
            sum_ff[3] <= sum_ff[3] + SW'(rd_data_ff[31:24]);
         end
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_fire) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_n_ff    <= n_ff;
         rsp_last_ff <= item_last_ff;
         if (n_ff == '0) begin
            rsp_ch_ff[0] <= item_pix_ff[23:16];
            rsp_ch_ff[1] <= item_pix_ff[15:8];
            rsp_ch_ff[2] <= item_pix_ff[7:0];
            rsp_ch_ff[3] <= item_pix_ff[31:24];
         end else begin
            for (int c = 0; c < 4; c++) begin
               rsp_ch_ff[c] <= sum_ff[c][7:0];
            end
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_avg_red      = rsp_ch_ff[0];
   assign rsp_avg_green    = rsp_ch_ff[1];
   assign rsp_avg_blue     = rsp_ch_ff[2];
   assign rsp_avg_alpha    = rsp_ch_ff[3];
   assign rsp_frames_used  = rsp_n_ff;
   assign rsp_end_of_frame = rsp_last_ff;

   // The number of frames summed never exceeds the frames kept.
   a_n_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tfas_pkg::ST_DIVIDE) |-> (n_ff <= kept_ff))
      else $error("more frames summed than kept");

   // Read data only arrives while the loop is reading or draining.
   a_rd_window: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> (state_ff == tfas_pkg::ST_READ || state_ff == tfas_pkg::ST_DRAIN))
      else $error("read data outside the read window");

   // An accepted transaction always starts with the memory write.
   a_accept_write: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == tfas_pkg::ST_WRITE))
      else $error("accepted pixel not written");

   // The result register is never overwritten while still held.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !out_load)
      else $error("result overwritten while stalled");

endmodule
